// ===== hdl/skf_pkg.sv =====
package skf_pkg;

  localparam int SAMPLE_BITS_DEF   = 12;
  localparam int FRACTION_BITS_DEF = 20;

  // gain and covariance are UQ0.32
  localparam int GAIN_BITS  = 32;
  localparam int NOISE_BITS = 31;
  localparam int FILT_BITS  = 12;
  localparam int STEP_BITS  = $clog2(GAIN_BITS);

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PROCESS_NOISE     = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_MEASUREMENT_NOISE = CFG_INDEX_BITS'(1);

  localparam logic [NOISE_BITS-1:0] PROCESS_NOISE_RST     = NOISE_BITS'(429497);
  localparam logic [NOISE_BITS-1:0] MEASUREMENT_NOISE_RST = NOISE_BITS'(21474836);

  // divide request: num < den is required
  typedef struct packed {
    logic                 start;
    logic [GAIN_BITS-1:0] num;
    logic [GAIN_BITS:0]   den;
  } div_req_t;

endpackage

// ===== hdl/skf_div.sv =====
module skf_div (
  input  logic                           clk,
  input  logic                           rst,
  input  skf_pkg::div_req_t              req,
  output logic [skf_pkg::GAIN_BITS-1:0]  quo,
  output logic                           done
);

  logic                            busy;
  logic [skf_pkg::STEP_BITS-1:0]   cnt;
  logic [skf_pkg::GAIN_BITS:0]     rem;
  logic [skf_pkg::GAIN_BITS:0]     den_r;
  logic [skf_pkg::GAIN_BITS+1:0]   rem_shift;
  logic [skf_pkg::GAIN_BITS+1:0]   rem_sub;
  logic                            ge;

  assign rem_shift = {rem, 1'b0};
  assign rem_sub   = rem_shift - {1'b0, den_r};
  assign ge        = rem_shift >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= skf_pkg::STEP_BITS'(skf_pkg::GAIN_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // one quotient bit per cycle, MSB first
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= {1'b0, req.num};
      den_r <= req.den;
      quo   <= '0;
    end else if (busy) begin
      rem <= ge ? rem_sub[skf_pkg::GAIN_BITS:0] : rem_shift[skf_pkg::GAIN_BITS:0];
      quo <= {quo[skf_pkg::GAIN_BITS-2:0], ge};
    end
  end

endmodule

// ===== hdl/skf_mul.sv =====
module skf_mul #(
  parameter int EST_BITS = skf_pkg::SAMPLE_BITS_DEF + skf_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [skf_pkg::GAIN_BITS-1:0]  gain,
  input  logic [EST_BITS-1:0]            diff,
  input  logic [skf_pkg::GAIN_BITS-1:0]  pp,
  output logic [EST_BITS-1:0]            delta,
  output logic [skf_pkg::GAIN_BITS-1:0]  cov,
  output logic                           done
);

  logic                            busy;
  logic [skf_pkg::STEP_BITS-1:0]   cnt;
  logic [skf_pkg::GAIN_BITS-1:0]   k;
  logic [EST_BITS-1:0]             diff_r;
  logic [skf_pkg::GAIN_BITS-1:0]   pp_r;
  logic [EST_BITS-1:0]             acc_d;
  logic [skf_pkg::GAIN_BITS-1:0]   acc_p;
  logic                            sticky;
  logic [EST_BITS:0]               sum_d;
  logic [skf_pkg::GAIN_BITS:0]     sum_p;

  assign sum_d = {1'b0, acc_d} + {1'b0, (k[0] ? diff_r : EST_BITS'(0))};
  assign sum_p = {1'b0, acc_p} + {1'b0, (k[0] ? pp_r : skf_pkg::GAIN_BITS'(0))};

  assign delta = acc_d;
  // (1 - K) * P' truncated is P' minus the rounded-up K * P'
  assign cov   = pp_r - acc_p - skf_pkg::GAIN_BITS'(sticky);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= skf_pkg::STEP_BITS'(skf_pkg::GAIN_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // shift-add, gain LSB first; dropped low bits of the covariance sum feed the sticky flag
  always_ff @(posedge clk) begin
    if (start) begin
      k      <= gain;
      diff_r <= diff;
      pp_r   <= pp;
      acc_d  <= '0;
      acc_p  <= '0;
      sticky <= 1'b0;
    end else if (busy) begin
      k      <= k >> 1;
      acc_d  <= sum_d[EST_BITS:1];
      acc_p  <= sum_p[skf_pkg::GAIN_BITS:1];
      sticky <= sticky | sum_p[0];
    end
  end

endmodule

// ===== hdl/scalar_kalman_sample_filter_top.sv =====
// An accepted request passes the prediction, gain, divide, multiply and finish states
// (divide is skipped when measurement noise is 0), using the bit-serial restoring divider
// (32 steps) and the bit-serial shift-add multiplier (32 steps). Requests are taken only in
// idle. A finished result waits in the output register while the next request is taken.
// Reset (rst, synchronous): estimate and covariance clear, noise registers take their
// default values, no request is in flight and the output is empty.
module scalar_kalman_sample_filter_top #(
  parameter int SAMPLE_BITS   = skf_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = skf_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [SAMPLE_BITS-1:0]              sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [skf_pkg::FILT_BITS-1:0]       filtered,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [skf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [skf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int EST_BITS = SAMPLE_BITS + FRACTION_BITS;
  localparam int GB = skf_pkg::GAIN_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRED = 3'd1;
  localparam logic [2:0] ST_GAIN = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]                        state;
  logic [2:0]                        state_next;
  logic [skf_pkg::NOISE_BITS-1:0]    process_noise;
  logic [skf_pkg::NOISE_BITS-1:0]    measurement_noise;
  logic [EST_BITS-1:0]               estimate;
  logic [GB-1:0]                     error_covariance;
  logic [SAMPLE_BITS-1:0]            sample_r;
  logic [GB-1:0]                     pp_r;
  logic [EST_BITS-1:0]               diff_r;
  logic                              dir_r;

  logic [GB:0]                       pp_sum;
  logic [GB-1:0]                     pp_c;
  logic [EST_BITS-1:0]               z_c;
  logic                              z_ge;
  logic                              out_free;

  skf_pkg::div_req_t                 div_req;
  logic [GB-1:0]                     div_quo;
  logic                              div_done;

  logic                              mul_start;
  logic [GB-1:0]                     mul_gain;
  logic [EST_BITS-1:0]               mul_delta;
  logic [GB-1:0]                     mul_cov;
  logic                              mul_done;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // predicted covariance, saturating at the top of UQ0.32
  assign pp_sum = {1'b0, error_covariance} + {2'b0, process_noise};
  assign pp_c   = pp_sum[GB] ? {GB{1'b1}} : pp_sum[GB-1:0];
  assign z_c    = {sample_r, FRACTION_BITS'(0)};
  assign z_ge   = z_c >= estimate;

  assign div_req.start = (state == ST_GAIN) && (measurement_noise != '0);
  assign div_req.num   = pp_r;
  assign div_req.den   = {1'b0, pp_r} + {2'b0, measurement_noise};

  // zero noise: gain is 0 for a zero prediction, else saturates to all ones
  assign mul_start = ((state == ST_GAIN) && (measurement_noise == '0))
                     || ((state == ST_DIV) && div_done);
  assign mul_gain  = (state == ST_GAIN) ? ((pp_r == '0) ? '0 : {GB{1'b1}}) : div_quo;

  skf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .quo  (div_quo),
    .done (div_done)
  );

  skf_mul #(
    .EST_BITS (EST_BITS)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .gain  (mul_gain),
    .diff  (diff_r),
    .pp    (pp_r),
    .delta (mul_delta),
    .cov   (mul_cov),
    .done  (mul_done)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_PRED;
        end
      end
      ST_PRED: begin
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        state_next = (measurement_noise == '0) ? ST_MUL : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      process_noise     <= skf_pkg::PROCESS_NOISE_RST;
      measurement_noise <= skf_pkg::MEASUREMENT_NOISE_RST;
      estimate          <= '0;
      error_covariance  <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          skf_pkg::REG_PROCESS_NOISE: begin
            process_noise <= cfg_data[skf_pkg::NOISE_BITS-1:0];
          end
          skf_pkg::REG_MEASUREMENT_NOISE: begin
            measurement_noise <= cfg_data[skf_pkg::NOISE_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
      if (state == ST_MUL && mul_done) begin
        estimate         <= dir_r ? estimate + mul_delta : estimate - mul_delta;
        error_covariance <= mul_cov;
      end
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= sample;
    end
    if (state == ST_PRED) begin
      pp_r   <= pp_c;
      dir_r  <= z_ge;
      diff_r <= z_ge ? z_c - estimate : estimate - z_c;
    end
    if (state == ST_FIN && out_free) begin
      filtered <= skf_pkg::FILT_BITS'(estimate >> FRACTION_BITS);
    end
  end

`ifndef NO_ASSERTIONS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL)
    else $error("multiplier finished outside the multiply phase");

  a_accept_to_pred: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_PRED)
    else $error("accepted request did not enter prediction");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && out_valid && !out_ready |=> state == ST_FIN)
    else $error("result left while the output register was full");
`endif

endmodule
